// ----- src/rau_pkg.sv -----
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;

  // field widths for results, action codes and status codes
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int ACT_W = 2;
  localparam int STS_W = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 2'd3;

  // status codes
  localparam logic [STS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STS_W-1:0] STS_DIV0 = 2'd1;
  localparam logic [STS_W-1:0] STS_ZGCD = 2'd2;

  // which operands feed the shared divider
  typedef enum logic [1:0] {
    SEL_EUC,
    SEL_NUM,
    SEL_DEN
  } div_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic [1:0]       mul_step;
    logic             div_start;
    div_sel_t         div_sel;
    logic             out_load;
    logic [STS_W-1:0] out_code;
  } rau_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic frac_zero;
    logic a_zero;
    logic b_zero;
    logic div_done;
  } rau_stat_t;

endpackage
`default_nettype wire

// ----- src/rau_divider.sv -----
// signed truncating divider, one quotient bit per cycle
`default_nettype none
module rau_divider #(
  parameter int XW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [XW-1:0] x,
  input  wire logic signed [XW-1:0] y,
  output logic                      done,
  output logic signed [XW-1:0]      quot,
  output logic signed [XW-1:0]      rem
);

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] rem_r;
  logic [XW-1:0] quo_r;
  logic [XW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg_q;
  logic          neg_r;
  logic [XW:0]   trial;
  logic [XW:0]   diff;
  logic          fits;

  // restoring step
  always_comb begin
    trial = {rem_r, quo_r[XW-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(XW);
        rem_r <= '0;
        quo_r <= x[XW-1] ? XW'(-x) : XW'(x);
        den_r <= y[XW-1] ? XW'(-y) : XW'(y);
        neg_q <= x[XW-1] ^ y[XW-1];
        neg_r <= x[XW-1];
      end else if (busy) begin
        rem_r <= fits ? diff[XW-1:0] : trial[XW-1:0];
        quo_r <= {quo_r[XW-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fix-up, remainder follows dividend
  assign quot = neg_q ? -$signed(quo_r) : $signed(quo_r);
  assign rem  = neg_r ? -$signed(rem_r) : $signed(rem_r);

endmodule
`default_nettype wire

// ----- src/rau_datapath.sv -----
// operand registers, multiplier, euclid registers and result register
`default_nettype none
module rau_datapath
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire rau_cmd_t                 cmd,
  output rau_stat_t                     stat,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic [OPERAND_WIDTH-1:0] left_num,
  input  wire logic [OPERAND_WIDTH-1:0] left_den,
  input  wire logic [OPERAND_WIDTH-1:0] right_num,
  input  wire logic [OPERAND_WIDTH-1:0] right_den,
  output logic [NUM_W-1:0]              result_num,
  output logic [DEN_W-1:0]              result_den,
  output logic [STS_W-1:0]              status
);

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;
  localparam int XW = (PW + 1 > 64) ? 64 : PW + 1;

  logic [ACT_W-1:0]     act;
  logic signed [OW-1:0] ln, ld, rn, rd;
  logic signed [OW-1:0] opa, opb;
  logic signed [PW-1:0] p;
  logic signed [XW-1:0] px;
  logic signed [XW-1:0] n, d, a, b;
  logic signed [XW-1:0] qn, qd;
  logic signed [XW-1:0] dx, dy;
  logic signed [XW-1:0] quot, rem;
  logic                 div_done;

  // multiplier operand selection per step
  always_comb begin
    unique case (cmd.mul_step)
      2'd0: begin
        opa = ln;
        opb = (act == ACT_MUL) ? rn : rd;
      end
      2'd1: begin
        opa = rn;
        opb = ld;
      end
      default: begin
        opa = ld;
        opb = (act == ACT_DIV) ? rn : rd;
      end
    endcase
    px = XW'(p);
  end

  // divider operand selection
  always_comb begin
    unique case (cmd.div_sel)
      SEL_EUC: begin
        dx = a;
        dy = b;
      end
      SEL_NUM: begin
        dx = n;
        dy = a;
      end
      default: begin
        dx = d;
        dy = a;
      end
    endcase
  end

  rau_divider #(.XW(XW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .x     (dx),
    .y     (dy),
    .done  (div_done),
    .quot  (quot),
    .rem   (rem)
  );

  // data registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      ln  <= left_num;
      ld  <= left_den;
      rn  <= right_num;
      rd  <= right_den;
    end
    if (cmd.mul_en) begin
      p <= opa * opb;
      case (cmd.mul_step)
        2'd1: n <= px;
        2'd2: begin
          if (act == ACT_ADD) begin
            n <= n + px;
          end else if (act == ACT_SUB) begin
            n <= n - px;
          end
        end
        2'd3: begin
          d <= px;
          a <= n;
          b <= px;
        end
        default: ;
      endcase
    end
    if (div_done) begin
      case (cmd.div_sel)
        SEL_EUC: begin
          a <= b;
          b <= rem;
        end
        SEL_NUM: qn <= quot;
        default: qd <= quot;
      endcase
    end
    if (cmd.out_load) begin
      status     <= cmd.out_code;
      result_num <= (cmd.out_code == STS_OK) ? NUM_W'(qn) : '0;
      result_den <= (cmd.out_code == STS_OK) ? DEN_W'(qd) : '0;
    end
  end

  // status to controller
  always_comb begin
    stat.frac_zero = (act == ACT_DIV) && (rn == '0);
    stat.a_zero    = (a == '0);
    stat.b_zero    = (b == '0);
    stat.div_done  = div_done;
  end

endmodule
`default_nettype wire

// ----- src/rau_ctrl.sv -----
// sequencing state machine for the rational arithmetic unit
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire rau_stat_t stat,
  output rau_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_EUC,
    ST_EUC_W,
    ST_QN,
    ST_QN_W,
    ST_QD,
    ST_QD_W,
    ST_OUT
  } state_t;

  state_t           state;
  logic [STS_W-1:0] code;
  logic             out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.out_code = code;
    cmd.div_sel  = SEL_EUC;
    unique case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_M0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = 2'd0;
      end
      ST_M1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = 2'd1;
      end
      ST_M2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = 2'd2;
      end
      ST_M3: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = 2'd3;
      end
      ST_EUC:   cmd.div_start = !stat.b_zero;
      ST_EUC_W: cmd.div_sel = SEL_EUC;
      ST_QN: begin
        cmd.div_sel   = SEL_NUM;
        cmd.div_start = 1'b1;
      end
      ST_QN_W: cmd.div_sel = SEL_NUM;
      ST_QD: begin
        cmd.div_sel   = SEL_DEN;
        cmd.div_start = 1'b1;
      end
      ST_QD_W: cmd.div_sel = SEL_DEN;
      ST_OUT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      code      <= STS_OK;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_M0;
          end
        end
        ST_M0: begin
          if (stat.frac_zero) begin
            code  <= STS_DIV0;
            state <= ST_OUT;
          end else begin
            state <= ST_M1;
          end
        end
        ST_M1: state <= ST_M2;
        ST_M2: state <= ST_M3;
        ST_M3: state <= ST_EUC;
        ST_EUC: begin
          if (!stat.b_zero) begin
            state <= ST_EUC_W;
          end else if (stat.a_zero) begin
            code  <= STS_ZGCD;
            state <= ST_OUT;
          end else begin
            state <= ST_QN;
          end
        end
        ST_EUC_W: if (stat.div_done) state <= ST_EUC;
        ST_QN:    state <= ST_QN_W;
        ST_QN_W:  if (stat.div_done) state <= ST_QD;
        ST_QD:    state <= ST_QD_W;
        ST_QD_W: begin
          if (stat.div_done) begin
            code  <= STS_OK;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            code      <= STS_OK;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/rational_arith_unit.sv -----
// top level of the rational arithmetic unit
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  action, left_num, left_den, right_num, right_den
//   out      source     out_valid/out_stall  result_num, result_den, status
//
// one request at a time; in_stall is high from acceptance until the result is registered
// a request runs the four product steps, then one euclid check and division per euclid
// step, a last euclid check, the two final divisions of width XW and the output, with
// XW = min(2*OPERAND_WIDTH+1, 64), all on one bit-serial divider
// a divide by a zero fraction goes from the first product step straight to the output
// rst is synchronous and clears the controller; the result register holds until taken
`default_nettype none
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic [OPERAND_WIDTH-1:0] left_num,
  input  wire logic [OPERAND_WIDTH-1:0] left_den,
  input  wire logic [OPERAND_WIDTH-1:0] right_num,
  input  wire logic [OPERAND_WIDTH-1:0] right_den,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [NUM_W-1:0]              result_num,
  output logic [DEN_W-1:0]              result_den,
  output logic [STS_W-1:0]              status
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .left_num   (left_num),
    .left_den   (left_den),
    .right_num  (right_num),
    .right_den  (right_den),
    .result_num (result_num),
    .result_den (result_den),
    .status     (status)
  );

endmodule
`default_nettype wire

// ----- src/rau_checker.sv -----
// port-level checks for the rational arithmetic unit, bound to the top level
`default_nettype none
module rau_checker
  import rau_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [NUM_W-1:0] result_num,
  input wire logic [DEN_W-1:0] result_den,
  input wire logic [STS_W-1:0] status
);

  // one request in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // no result in the cycle after a request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_num) && $stable(status))
    else $error("stalled result changed");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STS_DIV0 || status == STS_ZGCD)
      |-> result_num == '0 && result_den == '0)
    else $error("error result not zero");

  // only defined status codes
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STS_OK || status == STS_DIV0 || status == STS_ZGCD)
    else $error("bad status code");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
`default_nettype wire

// ----- verif/rational_arith_unit_tb.sv -----
// testbench for the rational arithmetic unit: directed and random fraction requests
`default_nettype none
module rational_arith_unit_tb
  import rau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OW = 16;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [STS_W-1:0] sts;
  } fraction_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0] action = ACT_ADD;
  logic [OW-1:0] left_num = '0, left_den = '0, right_num = '0, right_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [NUM_W-1:0] result_num;
  logic [DEN_W-1:0] result_den;
  logic [STS_W-1:0] status;

  fraction_res_t reduced_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  rational_arith_unit #(.OPERAND_WIDTH(OW)) DUT (.*);

  always #5 clk = ~clk;

  // reduce the cross products with euclid, signs as truncating division gives them
  function automatic fraction_res_t reduce_fraction(logic [ACT_W-1:0] act,
      logic [OW-1:0] ln, logic [OW-1:0] ld, logic [OW-1:0] rn, logic [OW-1:0] rd);
    fraction_res_t res;
    longint sln, sld, srn, srd, n, d, a, b, r, qn, qd;
    res = '0;
    sln = longint'($signed(ln));
    sld = longint'($signed(ld));
    srn = longint'($signed(rn));
    srd = longint'($signed(rd));
    case (act)
      ACT_ADD: begin n = sln * srd + srn * sld; d = sld * srd; end
      ACT_SUB: begin n = sln * srd - srn * sld; d = sld * srd; end
      ACT_MUL: begin n = sln * srn; d = sld * srd; end
      default: begin
        if (srn == 0) begin
          res.sts = STS_DIV0;
          return res;
        end
        n = sln * srd;
        d = sld * srn;
      end
    endcase
    a = n;
    b = d;
    while (b != 0) begin
      r = (b == 1 || b == -1) ? 0 : a % b;
      a = b;
      b = r;
    end
    if (a == 0) begin
      res.sts = STS_ZGCD;
      return res;
    end
    qn = (a == -1) ? -n : n / a;
    qd = (a == -1) ? -d : d / a;
    res.num = qn[NUM_W-1:0];
    res.den = qd[DEN_W-1:0];
    res.sts = STS_OK;
    return res;
  endfunction

  // offer one request, record its expectation once taken, then maybe idle
  task automatic send_request(logic [ACT_W-1:0] act, logic [OW-1:0] ln, logic [OW-1:0] ld,
      logic [OW-1:0] rn, logic [OW-1:0] rd);
    int gap;
    in_valid <= 1'b1;
    action <= act;
    left_num <= ln;
    left_den <= ld;
    right_num <= rn;
    right_den <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reduced_q.push_back(reduce_fraction(act, ln, ld, rn, rd));
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reduced_q.size() != 0) @(posedge clk);
  endtask

  // operand mix: zero, extremes, small values with common factors, full range
  function automatic logic [OW-1:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2, 3, 4: return OW'($signed($urandom_range(40)) - 20);
      default: return OW'($urandom);
    endcase
  endfunction

  // receiver side: random stall, or a long hold-off when one is counting down
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare every taken result with the oldest expectation
  always @(posedge clk) begin
    fraction_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reduced_q.size() == 0) begin
        $display("%0t unexpected result num=%0d den=%0d status=%0d", $time,
                 $signed(result_num), $signed(result_den), status);
        errors++;
      end else begin
        want = reduced_q.pop_front();
        if (status !== want.sts) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, want.sts, status);
          errors++;
        end
        if (result_num !== want.num) begin
          $display("%0t result_num mismatch: expected %0d actual %0d", $time,
                   $signed(want.num), $signed(result_num));
          errors++;
        end
        if (result_den !== want.den) begin
          $display("%0t result_den mismatch: expected %0d actual %0d", $time,
                   $signed(want.den), $signed(result_den));
          errors++;
        end
      end
    end
  end

  // extremes, every action and the special cases
  task automatic test_directed();
    send_request(ACT_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_request(ACT_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_request(ACT_MUL, -16'sd6, 16'd4, 16'd2, -16'sd9);
    send_request(ACT_DIV, 16'd3, 16'd5, -16'sd7, 16'd10);
    // divide by a zero fraction
    send_request(ACT_DIV, 16'd3, 16'd5, 16'd0, 16'd10);
    send_request(ACT_DIV, 16'h8000, 16'h8000, 16'd0, 16'd0);
    // numerator and denominator both zero
    send_request(ACT_ADD, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(ACT_MUL, 16'd0, 16'd0, 16'd4, 16'd7);
    // zero denominator with nonzero numerator
    send_request(ACT_ADD, 16'd3, 16'd0, 16'd2, 16'd5);
    send_request(ACT_DIV, 16'd3, 16'd0, 16'd2, 16'd5);
    // zero numerator, nonzero denominator
    send_request(ACT_MUL, 16'd0, -16'sd3, 16'd5, 16'd7);
    // extremes
    send_request(ACT_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(ACT_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_request(ACT_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_request(ACT_SUB, 16'h7fff, 16'hffff, 16'h8000, 16'h0001);
    send_request(ACT_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(ACT_ADD, 16'h7fff, 16'h7ffe, 16'h7ffd, 16'h7fff);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count)
      send_request(ACT_W'($urandom_range(3)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
    wait_drained();
  endtask

  // long receiver hold-off while requests keep coming, then a full drain
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left <= 4000;
    repeat (4)
      send_request(ACT_W'($urandom_range(3)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
    wait_drained();
    send_request(ACT_MUL, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(90, 0, 0);
    test_random(85, 77, 0);
    test_random(85, 0, 77);
    test_backpressure();
    test_random(85, 7, 7);
    repeat (100) @(posedge clk);
    if (errors == 0 && reduced_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
